>>> design/swfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_pkg: shared types and constants of the write frame encoder
// Item structs, action codes, UART symbol values and the job format that
// travels from the front end through the queue to the symbol sequencer.
// ----------------------------------------------------------------------------
package swfe_pkg;

	// Action codes of an input item
	localparam logic [1:0] ACT_HEADER = 2'd0;
	localparam logic [1:0] ACT_DATA   = 2'd1;
	localparam logic [1:0] ACT_END    = 2'd2;

	// UART symbols for one wire bit
	localparam logic [7:0] SYM_ONE  = 8'h80;
	localparam logic [7:0] SYM_ZERO = 8'hFE;

	// Fixed header words
	localparam logic [7:0] HDR_CMD  = 8'h5A;
	localparam logic [7:0] HDR_TAIL = 8'h00;

	// Word layout: start symbol, eight data symbols, stop symbol
	localparam int          SYMS_PER_WORD = 10;
	localparam int          SYM_CNT_W     = 4;
	localparam logic [SYM_CNT_W-1:0] SYM_FIRST = SYM_CNT_W'(0);
	localparam logic [SYM_CNT_W-1:0] SYM_LAST  = SYM_CNT_W'(SYMS_PER_WORD - 1);

	// A job holds at most five words
	localparam int          JOB_WORDS   = 5;
	localparam int          WORD_CNT_W  = 3;
	localparam int          JOB_BITS    = JOB_WORDS * 8;
	localparam logic [WORD_CNT_W-1:0] WORDS_M1_HEADER = WORD_CNT_W'(JOB_WORDS - 1);
	localparam logic [WORD_CNT_W-1:0] WORDS_M1_SINGLE = WORD_CNT_W'(0);

	// Default depth of the job queue
	localparam int          QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  action;
		logic [23:0] address;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] uart_byte;
		logic       last_of_run;
	} out_item_t;

	// Classified work for the sequencer; word 0 sits in the top byte
	typedef struct packed {
		logic [WORD_CNT_W-1:0] words_m1;
		logic                  first_one;
		logic                  all_ones;
		logic [JOB_BITS-1:0]   payload;
	} job_t;

endpackage

>>> design/swfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_front: input classifier
// Turns an accepted input item into a job and pushes it into the queue;
// drops items with an unused action code.
// ----------------------------------------------------------------------------
module swfe_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  swfe_pkg::in_item_t in_item,
	input  logic               queue_full,
	output logic               push,
	output swfe_pkg::job_t     push_job
);

	logic keep;

	assign in_ready = !queue_full;

	always_comb begin
		keep     = 1'b1;
		push_job = '0;
		unique case (in_item.action)
			swfe_pkg::ACT_HEADER: begin
				push_job.words_m1  = swfe_pkg::WORDS_M1_HEADER;
				push_job.first_one = 1'b1;
				push_job.all_ones  = 1'b0;
				push_job.payload   = {swfe_pkg::HDR_CMD, in_item.address, swfe_pkg::HDR_TAIL};
			end
			swfe_pkg::ACT_DATA: begin
				push_job.words_m1  = swfe_pkg::WORDS_M1_SINGLE;
				push_job.first_one = 1'b0;
				push_job.all_ones  = 1'b0;
				push_job.payload   = {in_item.data_byte, 32'h0};
			end
			swfe_pkg::ACT_END: begin
				push_job.words_m1  = swfe_pkg::WORDS_M1_SINGLE;
				push_job.first_one = 1'b1;
				push_job.all_ones  = 1'b1;
				push_job.payload   = {8'hFF, 32'h0};
			end
			default: begin
				// unused action: accept and drop
				keep = 1'b0;
			end
		endcase
	end

	assign push = in_valid && in_ready && keep;

endmodule

>>> design/swfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_queue: job queue
// Short first-in first-out store between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module swfe_queue #(
	parameter int DEPTH = swfe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swfe_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           job_valid,
	output swfe_pkg::job_t job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	swfe_pkg::job_t   store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign job_valid = (count_q != '0);
	assign job       = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/swfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_back: symbol sequencer
// Walks a job word by word and symbol by symbol, one symbol per cycle
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module swfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  swfe_pkg::job_t      job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output swfe_pkg::out_item_t out_item
);

	localparam int TOP = swfe_pkg::JOB_BITS - 1;

	logic                               busy_q;
	logic [swfe_pkg::SYM_CNT_W-1:0]     sym_cnt_q;
	logic [swfe_pkg::WORD_CNT_W-1:0]    word_cnt_q;
	logic [swfe_pkg::WORD_CNT_W-1:0]    words_m1_q;
	logic                               first_one_q;
	logic                               all_ones_q;
	logic [swfe_pkg::JOB_BITS-1:0]      payload_q;
	logic                               out_valid_q;
	swfe_pkg::out_item_t                out_item_q;

	logic                advance;
	logic                step;
	logic                last_sym;
	logic                end_of_word;
	logic [7:0]          sym;

	assign advance     = !out_valid_q || out_ready;
	assign step        = busy_q && advance;
	assign end_of_word = (sym_cnt_q == swfe_pkg::SYM_LAST);
	assign last_sym    = end_of_word && (word_cnt_q == words_m1_q);
	assign pop         = job_valid && (!busy_q || (step && last_sym));

	always_comb begin
		priority if (sym_cnt_q == swfe_pkg::SYM_FIRST) begin
			sym = (all_ones_q || (first_one_q && word_cnt_q == '0)) ?
				swfe_pkg::SYM_ONE : swfe_pkg::SYM_ZERO;
		end else if (end_of_word) begin
			sym = all_ones_q ? swfe_pkg::SYM_ONE : swfe_pkg::SYM_ZERO;
		end else begin
			sym = payload_q[TOP] ? swfe_pkg::SYM_ONE : swfe_pkg::SYM_ZERO;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sym_cnt_q   <= '0;
			word_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q     <= 1'b1;
				sym_cnt_q  <= '0;
				word_cnt_q <= '0;
			end else if (step) begin
				if (last_sym) begin
					busy_q <= 1'b0;
				end
				if (end_of_word) begin
					sym_cnt_q  <= '0;
					word_cnt_q <= word_cnt_q + swfe_pkg::WORD_CNT_W'(1);
				end else begin
					sym_cnt_q <= sym_cnt_q + swfe_pkg::SYM_CNT_W'(1);
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.uart_byte   <= sym;
			out_item_q.last_of_run <= last_sym;
		end
		if (pop) begin
			words_m1_q  <= job.words_m1;
			first_one_q <= job.first_one;
			all_ones_q  <= job.all_ones;
			payload_q   <= job.payload;
		end else if (step && sym_cnt_q != swfe_pkg::SYM_FIRST && !end_of_word) begin
			payload_q <= {payload_q[TOP-1:0], 1'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (sym_cnt_q <= swfe_pkg::SYM_LAST))
		else $error("symbol counter out of range");

	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (word_cnt_q <= words_m1_q))
		else $error("word counter past end of job");

	a_sym_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.uart_byte == swfe_pkg::SYM_ONE ||
			out_item_q.uart_byte == swfe_pkg::SYM_ZERO))
		else $error("output symbol is not a wire bit");

	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !out_valid_q) |=> !out_valid_q)
		else $error("symbol emitted without a job");
`endif

endmodule

>>> design/swire_write_frame_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swire_write_frame_encoder_top: single-wire write frame to UART symbols
// Expands header, data and end items into streams of UART bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_item) takes one frame item per
//   transfer: a header with a 24-bit address, a data byte, or an end mark.
//   Output channel (out_valid / out_ready / out_item) gives one UART symbol
//   per transfer, 0x80 for a wire one and 0xFE for a wire zero; last_of_run
//   flags the final symbol of each input item.
//   A header gives 50 symbols, a data item 10, an end item 10 ones. An item
//   with the unused action code is accepted and gives nothing.
//   When the sequencer is free, the first symbol of an item passes the queue
//   register, the sequencer's state registers and then the output register.
//   Throughput: one symbol per cycle while out_ready is high, set by the
//   sequencer's single output stage, with no gap between items while the
//   queue holds work.
//   The queue holds QUEUE_DEPTH jobs, so input keeps flowing while a long
//   header is still being sent.
//   Reset empties the queue and output stage; there is no clearing pass.
//   When the receiver stalls, hold the current symbol, freeze the sequencer,
//   and let the queue fill; in_ready falls only when the queue is full.
// ----------------------------------------------------------------------------
module swire_write_frame_encoder_top #(
	parameter int QUEUE_DEPTH = swfe_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swfe_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output swfe_pkg::out_item_t out_item
);

	// front to queue
	logic           push;
	swfe_pkg::job_t push_job;
	logic           queue_full;

	// queue to sequencer
	logic           pop;
	logic           job_valid;
	swfe_pkg::job_t job;

	// Classify each accepted item into a job; drop unused codes here.
	swfe_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	// Decouple input acceptance from symbol output.
	swfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.job_valid (job_valid),
		.job       (job)
	);

	// Emit one symbol per cycle unless out_ready stalls the output; take the next job on the last symbol, or when idle.
	swfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
